// ----- hw/rtl/sbdec_pkg.sv -----
// ----------------------------------------------------------------------------
// sbdec_pkg
// Shared constants, command codes and control structs of the SBUS channel
// decoder.
// ----------------------------------------------------------------------------
package sbdec_pkg;

  // Behavior constants of the decoder.
  localparam int unsigned CHANNELS          = 8;
  localparam int unsigned DEADBAND_WIDTH    = 10;
  localparam int unsigned TIMEOUT_TICKS     = 100;
  localparam int unsigned HEADER_VALUE      = 15;
  localparam int unsigned FOOTER_VALUE      = 0;
  localparam int unsigned DEADMAN_THRESHOLD = 1192;

  // Frame layout: header, 22 channel bytes, flag byte, footer.
  localparam int unsigned FRAME_LEN    = 25;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned CH_BYTES     = 22;
  localparam int unsigned FLAG_POS     = 23;
  localparam int unsigned FOOTER_POS   = 24;
  localparam int unsigned FRAME_BITS   = CH_BYTES * 8;
  localparam int unsigned NUM_CH       = 8;
  localparam int unsigned CH_W         = 11;
  localparam int unsigned CH_IDX_W     = 3;
  localparam int unsigned DEADMAN_CH   = 5;
  localparam logic [CH_W-1:0] CHAN_RESET = 11'd992;

  // Tick counter.
  localparam int unsigned TICK_W = 16;

  // Calibration registers.
  localparam int unsigned NUM_CAL = 8;
  localparam int unsigned CAL_AW  = 3;
  localparam int unsigned CAL_W   = 33;
  localparam logic [CAL_W-1:0] CAL_RESET = 33'd7597916332;

  // Configuration port.
  localparam int unsigned CFG_AW = 6;
  localparam int unsigned CFG_DW = 64;

  // Stream payload widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned SCALED_W    = 8;

  // Divider sizes: magnitude of (difference * 100) over magnitude of the span.
  localparam int unsigned DIV_NUM_W = 18;
  localparam int unsigned DIV_DEN_W = 11;
  localparam int unsigned DIV_CNT_W = 5;

  // Input command codes.
  localparam logic [IN_TUSER_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [IN_TUSER_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [IN_TUSER_W-1:0] CMD_QUERY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                byte_en;
    logic                tick_en;
    logic                prep;
    logic                div_start;
    logic                load_out;
    logic [CH_IDX_W-1:0] ch_idx;
    logic                last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_stall;
  } dp_status_t;

endpackage

// ----- hw/rtl/sbdec_ram.sv -----
// ----------------------------------------------------------------------------
// sbdec_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sbdec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hw/rtl/sbdec_div.sv -----
// ----------------------------------------------------------------------------
// sbdec_div
// Unsigned restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbdec_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sbdec_pkg::DIV_NUM_W-1:0] num,
  input  logic [sbdec_pkg::DIV_DEN_W-1:0] den,
  output logic                            done,
  output logic [sbdec_pkg::DIV_NUM_W-1:0] quot
);

  logic                            busy_r;
  logic                            done_r;
  logic [sbdec_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [sbdec_pkg::DIV_DEN_W-1:0] rem_r;
  logic [sbdec_pkg::DIV_NUM_W-1:0] quot_r;
  logic [sbdec_pkg::DIV_DEN_W:0]   shifted;
  logic                            fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign shifted = {rem_r, quot_r[sbdec_pkg::DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};

  // Control: busy flag, step counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= sbdec_pkg::DIV_CNT_W'(sbdec_pkg::DIV_NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= num;
    end else if (busy_r) begin
      rem_r  <= fits ? sbdec_pkg::DIV_DEN_W'(shifted - {1'b0, den})
                     : shifted[sbdec_pkg::DIV_DEN_W-1:0];
      quot_r <= {quot_r[sbdec_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- hw/rtl/sbdec_datapath.sv -----
// ----------------------------------------------------------------------------
// sbdec_datapath
// Frame collection, channel store, calibration memory, scaling arithmetic
// and the result register of the SBUS channel decoder.
// ----------------------------------------------------------------------------
module sbdec_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbdec_pkg::ctrl_cmd_t              cmd,
  output sbdec_pkg::dp_status_t             status,
  input  logic [sbdec_pkg::IN_TDATA_W-1:0]  rx_byte,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sbdec_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [sbdec_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [sbdec_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sbdec_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast
);

  localparam int unsigned CW  = sbdec_pkg::CH_W;
  localparam int unsigned XW  = CW + 1;
  localparam int unsigned PW  = 19;
  localparam int unsigned RW  = 20;
  localparam int unsigned SW  = sbdec_pkg::SCALED_W;
  localparam int unsigned PAD = sbdec_pkg::OUT_TDATA_W - sbdec_pkg::CH_IDX_W - CW - SW - 4;

  // --------------------------------------------------------------------------
  // Frame collection and channel store
  // --------------------------------------------------------------------------
  logic [sbdec_pkg::POS_W-1:0]      pos_r;
  logic [sbdec_pkg::FRAME_BITS-1:0] frame_r;
  logic [1:0]                       flags_r;
  logic [CW-1:0]                    chan_r [sbdec_pkg::NUM_CH];
  logic                             lost_r;
  logic                             fs_r;
  logic                             seen_r;
  logic [sbdec_pkg::TICK_W-1:0]     ticks_r;
  logic                             footer_ok;

  assign footer_ok = rx_byte == sbdec_pkg::IN_TDATA_W'(sbdec_pkg::FOOTER_VALUE);

  // Position counter, channel values, flags and the time-since-frame counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      lost_r  <= 1'b0;
      fs_r    <= 1'b0;
      seen_r  <= 1'b0;
      ticks_r <= '0;
      for (int k = 0; k < sbdec_pkg::NUM_CH; k++) begin
        chan_r[k] <= sbdec_pkg::CHAN_RESET;
      end
    end else if (cmd.byte_en) begin
      if (pos_r == '0) begin
        if (rx_byte == sbdec_pkg::IN_TDATA_W'(sbdec_pkg::HEADER_VALUE)) begin
          pos_r <= pos_r + 1'b1;
        end
      end else if (pos_r == sbdec_pkg::POS_W'(sbdec_pkg::FOOTER_POS)) begin
        pos_r <= '0;
        if (footer_ok) begin
          for (int k = 0; k < sbdec_pkg::NUM_CH; k++) begin
            chan_r[k] <= frame_r[k*CW +: CW];
          end
          lost_r  <= flags_r[0];
          fs_r    <= flags_r[1];
          seen_r  <= 1'b1;
          ticks_r <= '0;
        end
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end else if (cmd.tick_en) begin
      if (ticks_r != '1) begin
        ticks_r <= ticks_r + 1'b1;
      end
    end
  end

  // Channel bytes shift in from the top, so byte one ends in the lowest bits.
  always_ff @(posedge clk) begin
    if (cmd.byte_en && (pos_r != '0)) begin
      if (pos_r <= sbdec_pkg::POS_W'(sbdec_pkg::CH_BYTES)) begin
        frame_r <= {rx_byte, frame_r[sbdec_pkg::FRAME_BITS-1:8]};
      end else if (pos_r == sbdec_pkg::POS_W'(sbdec_pkg::FLAG_POS)) begin
        flags_r <= rx_byte[3:2];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Calibration memory with reset-value valid bits
  // --------------------------------------------------------------------------
  logic                          cal_we;
  logic [sbdec_pkg::CAL_AW-1:0]  cal_addr_a;
  logic [sbdec_pkg::CAL_W-1:0]   cal_rd_a;
  logic [sbdec_pkg::CAL_W-1:0]   cal_rd_b;
  logic [sbdec_pkg::NUM_CAL-1:0] cal_vld_r;
  logic                          vld_a_r;
  logic                          vld_b_r;
  logic [sbdec_pkg::CAL_W-1:0]   cal_a;
  logic [sbdec_pkg::CAL_W-1:0]   cal_b;

  assign cal_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cal_addr_a = cfg_paddr[sbdec_pkg::CFG_AW-1:3];

  sbdec_ram #(
    .WIDTH (sbdec_pkg::CAL_W),
    .DEPTH (sbdec_pkg::NUM_CAL)
  ) u_cal_ram (
    .clk     (clk),
    .we      (cal_we),
    .waddr   (cal_addr_a),
    .wdata   (cfg_pwdata[sbdec_pkg::CAL_W-1:0]),
    .raddr_a (cal_addr_a),
    .rdata_a (cal_rd_a),
    .raddr_b (cmd.ch_idx),
    .rdata_b (cal_rd_b)
  );

  // Valid bits follow the registered reads; an unwritten entry reads as reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_vld_r <= '0;
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
    end else begin
      vld_a_r <= cal_vld_r[cal_addr_a];
      vld_b_r <= cal_vld_r[cmd.ch_idx];
      if (cal_we) begin
        cal_vld_r[cal_addr_a] <= 1'b1;
      end
    end
  end

  assign cal_a      = vld_a_r ? cal_rd_a : sbdec_pkg::CAL_RESET;
  assign cal_b      = vld_b_r ? cal_rd_b : sbdec_pkg::CAL_RESET;
  assign cfg_prdata = {(sbdec_pkg::CFG_DW - sbdec_pkg::CAL_W)'(0), cal_a};

  // --------------------------------------------------------------------------
  // Operand preparation for one channel
  // --------------------------------------------------------------------------
  logic [CW-1:0]                    raw_sel;
  logic [XW-1:0]                    raw_x;
  logic [XW-1:0]                    lo_x;
  logic [XW-1:0]                    mid_x;
  logic [XW-1:0]                    hi_x;
  logic [XW-1:0]                    db_x;
  logic                             in_dz;
  logic                             below;
  logic signed [XW-1:0]             diff_s;
  logic signed [XW-1:0]             span_s;
  logic signed [PW-1:0]             prod_s;
  logic [sbdec_pkg::DIV_NUM_W-1:0]  num_mag;
  logic [sbdec_pkg::DIV_DEN_W-1:0]  den_mag;

  assign raw_sel = chan_r[cmd.ch_idx];
  assign raw_x   = {1'b0, raw_sel};
  assign lo_x    = {1'b0, cal_b[CW-1:0]};
  assign mid_x   = {1'b0, cal_b[2*CW-1:CW]};
  assign hi_x    = {1'b0, cal_b[3*CW-1:2*CW]};
  assign db_x    = XW'(sbdec_pkg::DEADBAND_WIDTH);

  // Deadband test, side of center, signed difference and span.
  assign in_dz  = ((raw_x + db_x) >= mid_x) && (raw_x <= (mid_x + db_x));
  assign below  = raw_x < mid_x;
  assign diff_s = below ? signed'(raw_x - lo_x) : signed'(raw_x - mid_x);
  assign span_s = below ? signed'(mid_x - lo_x) : signed'(hi_x - mid_x);
  assign prod_s = PW'(diff_s) * 19'sd100;

  // Sign-magnitude split for the unsigned divider.
  assign num_mag = prod_s[PW-1] ? sbdec_pkg::DIV_NUM_W'(-prod_s)
                                : prod_s[sbdec_pkg::DIV_NUM_W-1:0];
  assign den_mag = span_s[XW-1] ? sbdec_pkg::DIV_DEN_W'(-span_s)
                                : span_s[sbdec_pkg::DIV_DEN_W-1:0];

  logic [sbdec_pkg::DIV_NUM_W-1:0] num_r;
  logic [sbdec_pkg::DIV_DEN_W-1:0] den_r;
  logic                            neg_r;
  logic                            dz_r;
  logic                            below_r;
  logic                            zspan_r;
  logic [CW-1:0]                   raw_r;

  // Operand registers, loaded once per channel.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_r   <= num_mag;
      den_r   <= den_mag;
      neg_r   <= prod_s[PW-1] ^ span_s[XW-1];
      dz_r    <= in_dz;
      below_r <= below;
      zspan_r <= span_s == '0;
      raw_r   <= raw_sel;
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  logic                            div_done;
  logic [sbdec_pkg::DIV_NUM_W-1:0] quot;

  sbdec_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  // --------------------------------------------------------------------------
  // Result: sign, offset, special cases and clamp
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] q_ext;
  logic signed [RW-1:0] q_s;
  logic signed [RW-1:0] res_s;
  logic [SW-1:0]        scaled;
  logic                 deadman;
  logic                 link_ok;

  assign q_ext = signed'(RW'(quot));
  assign q_s   = neg_r ? -q_ext : q_ext;

  always_comb begin
    res_s = below_r ? (q_s - 20'sd100) : q_s;
    if (zspan_r) begin
      res_s = below_r ? -20'sd100 : 20'sd100;
    end
    if (res_s < -20'sd100) begin
      res_s = -20'sd100;
    end
    if (res_s > 20'sd100) begin
      res_s = 20'sd100;
    end
    if (dz_r) begin
      res_s = '0;
    end
  end

  assign scaled  = res_s[SW-1:0];
  assign deadman = chan_r[sbdec_pkg::DEADMAN_CH] > CW'(sbdec_pkg::DEADMAN_THRESHOLD);
  assign link_ok = seen_r && (ticks_r <= sbdec_pkg::TICK_W'(sbdec_pkg::TIMEOUT_TICKS))
                   && !lost_r && !fs_r;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                          out_valid_r;
  logic [sbdec_pkg::CH_IDX_W-1:0] out_idx_r;
  logic [CW-1:0]                 out_raw_r;
  logic [SW-1:0]                 out_scaled_r;
  logic                          out_dead_r;
  logic                          out_lost_r;
  logic                          out_fs_r;
  logic                          out_link_r;
  logic                          out_last_r;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx_r    <= cmd.ch_idx;
      out_raw_r    <= raw_r;
      out_scaled_r <= scaled;
      out_dead_r   <= deadman;
      out_lost_r   <= lost_r;
      out_fs_r     <= fs_r;
      out_link_r   <= link_ok;
      out_last_r   <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {PAD'(0), out_link_r, out_fs_r, out_lost_r, out_dead_r,
                       out_scaled_r, out_raw_r, out_idx_r};

  assign status.div_done  = div_done;
  assign status.out_stall = out_valid_r && !out_tready;

endmodule

// ----- hw/rtl/sbdec_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbdec_ctrl
// Controller of the SBUS channel decoder: accepts items and sequences a
// query through the channels one at a time.
// ----------------------------------------------------------------------------
module sbdec_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sbdec_pkg::IN_TUSER_W-1:0] in_tuser,
  input  sbdec_pkg::dp_status_t            status,
  output sbdec_pkg::ctrl_cmd_t             cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PREP,
    S_DIV,
    S_WAIT,
    S_LOAD
  } state_t;

  localparam logic [sbdec_pkg::CH_IDX_W-1:0] LAST_CH =
    sbdec_pkg::CH_IDX_W'(sbdec_pkg::CHANNELS - 1);

  state_t                         state_r;
  state_t                         state_nxt;
  logic [sbdec_pkg::CH_IDX_W-1:0] ch_r;
  logic [sbdec_pkg::CH_IDX_W-1:0] ch_nxt;
  logic                           accept;
  logic                           is_last;

  assign accept  = in_tvalid && (state_r == S_IDLE);
  assign is_last = ch_r == LAST_CH;

  // Next state and channel counter.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_tuser == sbdec_pkg::CMD_QUERY)) begin
          state_nxt = S_READ;
          ch_nxt    = '0;
        end
      end
      S_READ: state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  state_nxt = S_WAIT;
      S_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!status.out_stall) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
            ch_nxt    = ch_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Commands to the datapath.
  assign in_tready     = state_r == S_IDLE;
  assign cmd.byte_en   = accept && (in_tuser == sbdec_pkg::CMD_BYTE);
  assign cmd.tick_en   = accept && (in_tuser == sbdec_pkg::CMD_TICK);
  assign cmd.prep      = state_r == S_PREP;
  assign cmd.div_start = state_r == S_DIV;
  assign cmd.load_out  = (state_r == S_LOAD) && !status.out_stall;
  assign cmd.ch_idx    = ch_r;
  assign cmd.last      = is_last;

endmodule

// ----- hw/rtl/sbus_channel_decoder.sv -----
// ----------------------------------------------------------------------------
// sbus_channel_decoder
// Top level of the SBUS channel decoder: controller plus datapath.
// ----------------------------------------------------------------------------
// The block takes one item at a time on the input stream: a serial byte, a
// millisecond tick or a query, selected by in_tuser. A byte or a tick is
// absorbed without leaving the idle state. A query walks the channels one at
// a time through a shared one-bit-per-cycle divider; each channel passes
// through memory read, operand setup, 18 divider steps plus handoff and result
// load, and the input is held off for the whole query, also while the result
// register is stalled. The last result of a query sits in the output
// register while the next item is already accepted. The per-channel
// calibration registers sit behind the APB port at byte addresses 8*i and
// read back as their reset value until first written.
module sbus_channel_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sbdec_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic [sbdec_pkg::IN_TUSER_W-1:0]  in_tuser,   // [1:0] command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] channel_index, [13:3] raw_value, [21:14] scaled_command,
  // [22] deadman_pressed, [23] frame_lost_flag, [24] failsafe_flag,
  // [25] link_valid, [31:26] zero
  output logic [sbdec_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sbdec_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [sbdec_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [sbdec_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                              cfg_pready
);

  sbdec_pkg::ctrl_cmd_t  cmd;
  sbdec_pkg::dp_status_t status;

  // Controller.
  sbdec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  sbdec_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .rx_byte     (in_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  assign cfg_pready = 1'b1;

endmodule

// ----- hw/rtl/sbdec_checker.sv -----
// ----------------------------------------------------------------------------
// sbdec_checker
// Port-level assertions for the SBUS channel decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sbdec_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [sbdec_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sbdec_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast
);

  localparam logic [2:0] LAST_CH = 3'(sbdec_pkg::CHANNELS - 1);

  logic signed [7:0] scaled;
  assign scaled = signed'(out_tdata[21:14]);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The last result of a query reports the highest channel.
  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2:0] == LAST_CH)
    else $error("last result on wrong channel");

  // The calibrated command stays within its range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (scaled >= -8'sd100) && (scaled <= 8'sd100))
    else $error("scaled command out of range");

  // Link validity excludes the lost and failsafe flags.
  a_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25] |-> !out_tdata[23] && !out_tdata[24])
    else $error("link valid with a frame flag set");

  // After a query is accepted the input is held off while it runs.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == sbdec_pkg::CMD_QUERY) |=> !in_tready)
    else $error("input accepted during a query");

endmodule

bind sbus_channel_decoder sbdec_checker u_sbdec_checker (.*);

// ----- tb/sbus_channel_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// sbus_channel_decoder_tb
// Self-checking testbench for the SBUS channel decoder.
// ----------------------------------------------------------------------------
// Bytes, millisecond ticks and queries go into the input stream, and the
// calibration registers are programmed and read back over APB. A scoreboard
// keeps its own copy of the decoder state and calibration. For every accepted
// query it predicts the eight channel reports, and it checks each report that
// leaves the block, field by field, against the oldest prediction. Both stream
// sides idle at random, and the output side once holds off for a long stretch
// so that the block backs up into its input.
// ----------------------------------------------------------------------------
import sbdec_pkg::*;

// Bit positions of the flags in the flag byte of a frame.
localparam int LOST_BIT     = 2;
localparam int FAILSAFE_BIT = 3;

// Commands are limited to plus or minus full scale.
localparam int FULL_SCALE = 100;

// Mismatch lines shown before the rest are only counted.
localparam int MAX_SHOWN = 100;

// One channel report as the block should produce it.
typedef struct {
  logic [CH_IDX_W-1:0] index;
  logic [CH_W-1:0]     raw;
  logic [SCALED_W-1:0] cmd;
  logic                deadman;
  logic                lost;
  logic                failsafe;
  logic                link;
  logic                last;
} chan_report_t;

class decoder_scoreboard;
  logic [CAL_W-1:0]  cal [NUM_CAL];
  logic [7:0]        frame_buf [FRAME_LEN];
  int unsigned       frame_pos;
  logic [CH_W-1:0]   chan_val [NUM_CH];
  logic              lost_flag;
  logic              failsafe_flag;
  logic              frame_seen;
  logic [TICK_W-1:0] ticks;
  chan_report_t      report_q [$];
  int                errors;
  int                n_used;
  int                n_expected;
  int                n_checked;
  int                n_frames;
  int                n_rejected;

  function new();
    for (int i = 0; i < NUM_CAL; i++) cal[i] = CAL_RESET;
    for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = '0;
    for (int i = 0; i < NUM_CH; i++) chan_val[i] = CHAN_RESET;
    frame_pos     = 0;
    lost_flag     = 1'b0;
    failsafe_flag = 1'b0;
    frame_seen    = 1'b0;
    ticks         = '0;
    errors        = 0;
    n_used        = 0;
    n_expected    = 0;
    n_checked     = 0;
    n_frames      = 0;
    n_rejected    = 0;
  endfunction

  function void mismatch(string what, longint want, longint got);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("%0t: %s: expected %0d, actual %0d", $time, what, want, got);
    end else if (errors == MAX_SHOWN + 1) begin
      $display("%0t: further mismatches are counted but not shown", $time);
    end
  endfunction

  function void set_calibration(int idx, logic [CAL_W-1:0] value);
    cal[idx] = value;
  endfunction

  function void check_register(int idx, logic [CFG_DW-1:0] got);
    if (got !== CFG_DW'(cal[idx])) begin
      mismatch($sformatf("calibration register %0d readback", idx), cal[idx], got);
    end
  endfunction

  // Piecewise-linear calibration with deadband, truncating division, clamp.
  function int scaled_command(int ch);
    int lo;
    int mid;
    int hi;
    int v;
    int span;
    int r;
    lo  = cal[ch][10:0];
    mid = cal[ch][21:11];
    hi  = cal[ch][32:22];
    v   = chan_val[ch];
    if (v + int'(DEADBAND_WIDTH) >= mid && v <= mid + int'(DEADBAND_WIDTH)) return 0;
    if (v < mid) begin
      span = mid - lo;
      if (span == 0) begin
        r = -FULL_SCALE;
      end else begin
        r = (v - lo) * FULL_SCALE / span - FULL_SCALE;
      end
    end else begin
      span = hi - mid;
      if (span == 0) begin
        r = FULL_SCALE;
      end else begin
        r = (v - mid) * FULL_SCALE / span;
      end
    end
    if (r < -FULL_SCALE) r = -FULL_SCALE;
    if (r > FULL_SCALE) r = FULL_SCALE;
    return r;
  endfunction

  // Update the decoder state for one accepted item; a query queues reports.
  function void note_input(logic [IN_TUSER_W-1:0] cmd, logic [7:0] rx);
    logic [FRAME_BITS-1:0] payload;
    logic                  dead;
    logic                  link;
    chan_report_t          rep;
    n_used++;
    case (cmd)
      CMD_BYTE: begin
        // Outside a frame only the header byte counts.
        if (frame_pos == 0 && rx != 8'(HEADER_VALUE)) return;
        frame_buf[frame_pos] = rx;
        frame_pos++;
        if (frame_pos == FRAME_LEN) begin
          frame_pos = 0;
          if (frame_buf[FOOTER_POS] == 8'(FOOTER_VALUE)) begin
            for (int b = 0; b < CH_BYTES; b++) payload[8*b +: 8] = frame_buf[b + 1];
            for (int k = 0; k < NUM_CH; k++) chan_val[k] = payload[CH_W*k +: CH_W];
            lost_flag     = frame_buf[FLAG_POS][LOST_BIT];
            failsafe_flag = frame_buf[FLAG_POS][FAILSAFE_BIT];
            frame_seen    = 1'b1;
            ticks         = '0;
            n_frames++;
          end else begin
            n_rejected++;
          end
        end
      end
      CMD_TICK: begin
        // The counter sticks at full scale.
        if (ticks != '1) ticks++;
      end
      CMD_QUERY: begin
        dead = chan_val[DEADMAN_CH] > DEADMAN_THRESHOLD;
        link = frame_seen && ticks <= TIMEOUT_TICKS && !lost_flag && !failsafe_flag;
        for (int k = 0; k < CHANNELS; k++) begin
          rep.index    = CH_IDX_W'(k);
          rep.raw      = chan_val[k];
          rep.cmd      = SCALED_W'(scaled_command(k));
          rep.deadman  = dead;
          rep.lost     = lost_flag;
          rep.failsafe = failsafe_flag;
          rep.link     = link;
          rep.last     = (k == CHANNELS - 1);
          report_q.push_back(rep);
        end
        n_expected += CHANNELS;
      end
      default: begin
        // The unused command code is dropped.
        return;
      end
    endcase
  endfunction

  // Compare one report from the block with the oldest prediction.
  function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
    chan_report_t want;
    string        tag;
    n_checked++;
    if (report_q.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN) begin
        $display("%0t: channel report: expected none pending, actual tdata %h",
                 $time, data);
      end
      return;
    end
    want = report_q.pop_front();
    tag = $sformatf("channel %0d", want.index);
    if (data[2:0] !== want.index) mismatch({tag, " index"}, want.index, data[2:0]);
    if (data[13:3] !== want.raw) mismatch({tag, " raw value"}, want.raw, data[13:3]);
    if (data[21:14] !== want.cmd) begin
      mismatch({tag, " command"}, $signed(want.cmd), $signed(data[21:14]));
    end
    if (data[22] !== want.deadman) mismatch({tag, " deadman"}, want.deadman, data[22]);
    if (data[23] !== want.lost) mismatch({tag, " frame lost"}, want.lost, data[23]);
    if (data[24] !== want.failsafe) mismatch({tag, " failsafe"}, want.failsafe, data[24]);
    if (data[25] !== want.link) mismatch({tag, " link valid"}, want.link, data[25]);
    if (data[31:26] !== '0) mismatch({tag, " pad bits"}, 0, data[31:26]);
    if (last !== want.last) mismatch({tag, " tlast"}, want.last, last);
  endfunction
endclass

module sbus_channel_decoder_tb;

  localparam logic [IN_TUSER_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] FILL_BYTE = 8'hA5;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 30;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] rx_byte
  logic [IN_TUSER_W-1:0]  in_tuser;   // [1:0] command
  logic                   out_tvalid;
  logic                   out_tready;
  // [2:0] channel_index, [13:3] raw_value, [21:14] scaled_command,
  // [22] deadman_pressed, [23] frame_lost_flag, [24] failsafe_flag,
  // [25] link_valid, [31:26] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  decoder_scoreboard sb;
  logic [CH_W-1:0]   frame_vals [NUM_CH];
  bit                quiet;
  int                hold_requests;
  int                holds_served;
  int                quiet_cycles;

  sbus_channel_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side: short random stalls, and a long hold whenever one is asked.
  initial begin
    out_tready   = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests > holds_served) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(4, 0) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(2, 0)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check each report as it leaves the block, and stop if nothing moves.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("sbus_channel_decoder: mismatch");
      $finish;
    end
  end

  // Offer one item, after an occasional gap, and wait until it is taken.
  task automatic send_item(input logic [IN_TUSER_W-1:0] cmd, input logic [7:0] rx);
    @(negedge clk);
    if (!quiet && $urandom_range(5, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, rx);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Wait for every predicted report, then let the block settle.
  task automatic wait_drain();
    while (sb.report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [CAL_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(8 * idx);
    cfg_pwdata  <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_calibration(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input int idx);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_AW'(8 * idx);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.check_register(idx, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Send a whole frame built from frame_vals; ticks may fall between bytes.
  task automatic send_frame(input logic [7:0] flags, input bit footer_ok, input bit mixed);
    logic [191:0] payload;
    logic [7:0]   footer;
    // Finish any partial frame left by noise so that this one lines up.
    while (sb.frame_pos != 0) send_item(CMD_BYTE, FILL_BYTE);
    for (int i = 0; i < 6; i++) payload[32*i +: 32] = $urandom;
    for (int k = 0; k < NUM_CH; k++) payload[CH_W*k +: CH_W] = frame_vals[k];
    send_item(CMD_BYTE, 8'(HEADER_VALUE));
    for (int i = 0; i < CH_BYTES; i++) begin
      if (mixed && $urandom_range(9, 0) == 0) send_item(CMD_TICK, 8'($urandom));
      send_item(CMD_BYTE, payload[8*i +: 8]);
    end
    send_item(CMD_BYTE, flags);
    footer = footer_ok ? 8'(FOOTER_VALUE) : 8'(FOOTER_VALUE) ^ 8'($urandom_range(255, 1));
    send_item(CMD_BYTE, footer);
  endtask

  // Channel values that sit on the interesting points of a calibration.
  function automatic logic [CH_W-1:0] pick_value(logic [CAL_W-1:0] c);
    int mid;
    int db;
    mid = c[21:11];
    db  = DEADBAND_WIDTH;
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      2: return CH_W'(mid - db - 1);
      3: return CH_W'(mid - db);
      4: return CH_W'(mid + db);
      5: return CH_W'(mid + db + 1);
      6: return c[10:0];
      7: return c[32:22];
      8: return CH_W'(DEADMAN_THRESHOLD + $urandom_range(1, 0));
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic logic [CAL_W-1:0] pack_cal(int lo, int mid, int hi);
    return {hi[10:0], mid[10:0], lo[10:0]};
  endfunction

  // Main sequence.
  initial begin
    logic [CAL_W-1:0] cal_value;
    logic [63:0]      rnd;
    logic [7:0]       flags;

    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = CMD_BYTE;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    quiet         = 1'b0;
    hold_requests = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers hold their reset calibration before any write.
    for (int i = 0; i < NUM_CAL; i++) cfg_read(i);

    // Reset state, an unused command, and stray bytes before any header.
    send_item(CMD_QUERY, 8'hFF);
    send_item(CMD_UNUSED, 8'h5A);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);

    // Field extremes, deadband edges and the deadman threshold on a fresh link.
    frame_vals = '{11'd0, 11'd2047, 11'd172, 11'd1811, 11'd982, 11'd1193, 11'd1002, 11'd981};
    send_frame(8'h00, 1'b1, 1'b0);
    repeat (2) send_item(CMD_TICK, 8'h00);
    send_item(CMD_QUERY, 8'h00);

    // Three phases, each under its own calibration; the last without idling.
    for (int p = 0; p < 3; p++) begin
      idle_input();
      wait_drain();
      for (int i = 0; i < NUM_CAL; i++) begin
        if (p == 0) begin
          case (i)
            0: cal_value = '0;
            1: cal_value = '1;
            2: cal_value = pack_cal(2047, 1000, 0);     // inverted
            3: cal_value = pack_cal(900, 1000, 1100);   // narrow, forces clamping
            4: cal_value = pack_cal(1024, 1024, 2047);  // zero span below center
            5: cal_value = pack_cal(0, 1024, 1024);     // zero span above center
            6: cal_value = pack_cal(0, 1024, 2047);
            default: cal_value = CAL_RESET;
          endcase
        end else begin
          rnd       = {$urandom, $urandom};
          cal_value = rnd[CAL_W-1:0];
        end
        cfg_write(i, cal_value);
      end
      for (int i = 0; i < NUM_CAL; i++) cfg_read(i);
      quiet = (p == 2);

      // Output held off while queries keep coming: the block backs up.
      if (p == 1) begin
        hold_requests++;
        repeat (2) send_item(CMD_QUERY, 8'($urandom));
        repeat (2) send_item(CMD_TICK, 8'($urandom));
        idle_input();
        wait_drain();
      end

      // One frame per phase: the lost flag with ticks mixed in, then a bad
      // footer that must leave the channels alone, then the failsafe flag.
      for (int k = 0; k < NUM_CH; k++) frame_vals[k] = pick_value(sb.cal[k]);
      if (p == 0) begin
        send_frame(8'h01 << LOST_BIT, 1'b1, 1'b1);
      end else if (p == 1) begin
        send_frame(8'($urandom), 1'b0, 1'b0);
      end else begin
        flags = (8'($urandom) & 8'hF3) | (8'h01 << FAILSAFE_BIT);
        send_frame(flags, 1'b1, 1'b0);
      end
      send_item(CMD_QUERY, 8'($urandom));
    end

    idle_input();
    wait_drain();
    repeat (60) @(posedge clk);

    $display("Run took %0d items: %0d good frames, %0d bad-footer frames, %0d reports checked.",
             sb.n_used, sb.n_frames, sb.n_rejected, sb.n_checked);
    $display("Calibration ran at reset, edge-case and random values; output held off once.");
    if (sb.errors == 0) begin
      $display("sbus_channel_decoder: match");
    end else begin
      $display("sbus_channel_decoder: mismatch");
    end
    $finish;
  end

endmodule
